// ===== rtl/shs_pkg.sv =====
// Shared types, constants and functions of the SHA-256/224 stream hasher.
// No dependencies; compiled first.
`default_nettype none
package shs_pkg;

  typedef struct packed {
    logic load;
    logic run;
    logic use_mem;
    logic shift;
  } shs_ctrl_t;

  localparam logic [31:0] PadMark = 32'h8000_0000;
  localparam logic [2:0]  LastIdx256 = 3'd7;
  localparam logic [2:0]  LastIdx224 = 3'd6;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_value(input logic mode, input logic [2:0] idx);
    logic [31:0] r;
    r = 32'h0;
    if (mode) begin
      unique case (idx)
        3'd0: r = 32'hc1059ed8;
        3'd1: r = 32'h367cd507;
        3'd2: r = 32'h3070dd17;
        3'd3: r = 32'hf70e5939;
        3'd4: r = 32'hffc00b31;
        3'd5: r = 32'h68581511;
        3'd6: r = 32'h64f98fa7;
        default: r = 32'hbefa4fa4;
      endcase
    end else begin
      unique case (idx)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    unique case (t)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/shs_if.sv =====
// Valid/ready channel interfaces of the hasher: message input, digest output
// and mode register write. Standalone; no package needed.
`default_nettype none
interface shs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        end_of_message;
  modport source (output valid, message_word, byte_count, end_of_message, input ready);
  modport sink (input valid, message_word, byte_count, end_of_message, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface shs_cfg_if;
  logic valid;
  logic ready;
  logic digest_mode;
  modport source (output valid, digest_mode, input ready);
  modport sink (input valid, digest_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/shs_word_ram.sv =====
// Generic one-write, one-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module shs_word_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/shs_round.sv =====
// Working variables, message schedule window and the SHA-256 round function.
// Depends on shs_pkg.
`default_nettype none
module shs_round (
  input  wire logic              clk,
  input  wire shs_pkg::shs_ctrl_t ctrl,
  input  wire logic [31:0]       k,
  input  wire logic [31:0]       block_word,
  input  wire logic [31:0]       hash_word,
  output logic      [31:0]       v0
);
  import shs_pkg::*;

  logic [31:0] v [8];
  logic [31:0] win [16];
  logic [31:0] sched, w, s1, s0, ch, mj, t1, t2;

  always_comb begin
    sched = (rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10)) + win[9] +
            (rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3)) + win[0];
    w  = ctrl.use_mem ? block_word : sched;
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + k + w;
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.shift) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= hash_word;
    end else if (ctrl.run) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w;
    end
  end

  assign v0 = v[0];
endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hasher_unit.sv =====
// Top level of the SHA-256/224 stream hasher: byte packing, padding sequencer,
// block and hash memories. Depends on shs_pkg, shs_if, shs_word_ram, shs_round.
// A message word that completes a block starts a compression: hash load, rounds and
// add-back, sequenced around the block and hash memories.
// End of message: padding writes plus one or two compressions, then the digest words
// go out one by one (8 or 7 words), each held until the output is ready.
// Reset and a mode write run a sweep loading the initial hash values.
`default_nettype none
module sha256_stream_hasher_unit (
  input wire logic clk,
  input wire logic rst,
  shs_in_if.sink   msg,
  shs_out_if.source digest,
  shs_cfg_if.sink  cfg
);
  import shs_pkg::*;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HLOAD = 4'd2;
  localparam logic [3:0] ST_ROUND = 4'd3;
  localparam logic [3:0] ST_HADD  = 4'd4;
  localparam logic [3:0] ST_MARK  = 4'd5;
  localparam logic [3:0] ST_PAD   = 4'd6;
  localparam logic [3:0] ST_ORD   = 4'd7;
  localparam logic [3:0] ST_OWAIT = 4'd8;

  logic [3:0]  state;
  logic [6:0]  cnt;
  logic        mode;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [31:0] pacc;
  logic        pad_pending, final_blk, extra;

  logic        acc;
  logic [2:0]  cnt_c;
  logic [1:0]  off;
  logic [31:0] wm;
  logic [63:0] cat;
  logic        wcomplete;
  logic [3:0]  widx;

  logic        b_we, b_re;
  logic [3:0]  b_wa, b_ra;
  logic [31:0] b_wd, b_rd;
  logic        h_we, h_re;
  logic [2:0]  h_wa, h_ra;
  logic [31:0] h_wd, h_rd;

  shs_ctrl_t   ctrl;
  logic [31:0] v0;
  logic [5:0]  k_idx;
  logic [2:0]  last_idx;

  assign acc       = msg.valid && msg.ready;
  assign cnt_c     = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
  assign off       = fill[1:0];
  assign widx      = fill[5:2];
  assign wm        = msg.message_word & ~(32'hffff_ffff >> {cnt_c, 3'b000});
  assign cat       = {pacc, 32'h0} | ({wm, 32'h0} >> {off, 3'b000});
  assign wcomplete = ({2'b00, off} + {1'b0, cnt_c}) >= 4'd4;
  assign last_idx  = mode ? LastIdx224 : LastIdx256;
  assign k_idx     = 6'(cnt - 7'd1);

  assign msg.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign digest.valid       = (state == ST_OWAIT);
  assign digest.digest_word = h_rd;
  assign digest.word_index  = cnt[2:0];
  assign digest.last_word   = (cnt[2:0] == last_idx);

  always_comb begin
    b_we = 1'b0;
    b_wa = widx;
    b_wd = cat[63:32];
    b_re = (state == ST_ROUND) && (cnt < 7'd16);
    b_ra = cnt[3:0];
    h_we = 1'b0;
    h_wa = cnt[2:0];
    h_wd = init_value(mode, cnt[2:0]);
    h_re = 1'b0;
    h_ra = cnt[2:0];
    ctrl = '0;
    unique case (state)
      ST_INIT: begin
        h_we = 1'b1;
      end
      ST_IDLE: begin
        b_we = acc && wcomplete;
      end
      ST_HLOAD: begin
        h_re      = (cnt < 7'd8);
        ctrl.load = (cnt != 7'd0);
      end
      ST_ROUND: begin
        ctrl.run     = (cnt != 7'd0);
        ctrl.use_mem = (cnt <= 7'd16);
      end
      ST_HADD: begin
        h_re       = (cnt < 7'd8);
        h_we       = (cnt != 7'd0);
        h_wa       = 3'(cnt - 7'd1);
        h_wd       = h_rd + v0;
        ctrl.shift = (cnt != 7'd0);
      end
      ST_MARK: begin
        b_we = 1'b1;
        b_wd = pacc | (PadMark >> {off, 3'b000});
      end
      ST_PAD: begin
        b_we = 1'b1;
        b_wa = cnt[3:0];
        if (!extra && cnt[3:0] == 4'd14) begin
          b_wd = bits[63:32];
        end else if (!extra && cnt[3:0] == 4'd15) begin
          b_wd = bits[31:0];
        end else begin
          b_wd = 32'h0;
        end
      end
      ST_ORD: begin
        h_re = 1'b1;
      end
      ST_OWAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      mode        <= 1'b0;
      fill        <= '0;
      bits        <= '0;
      pacc        <= '0;
      pad_pending <= 1'b0;
      final_blk   <= 1'b0;
      extra       <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      mode  <= cfg.digest_mode;
      state <= ST_INIT;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_INIT: begin
          fill        <= '0;
          bits        <= '0;
          pacc        <= '0;
          pad_pending <= 1'b0;
          final_blk   <= 1'b0;
          extra       <= 1'b0;
          cnt         <= cnt + 7'd1;
          if (cnt == 7'd7) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            bits <= bits + {58'h0, cnt_c, 3'b000};
            fill <= fill + {3'b000, cnt_c};
            pacc <= wcomplete ? cat[31:0] : cat[63:32];
            if (wcomplete && widx == 4'd15) begin
              state       <= ST_HLOAD;
              cnt         <= '0;
              pad_pending <= msg.end_of_message;
              final_blk   <= 1'b0;
            end else if (msg.end_of_message) begin
              state <= ST_MARK;
            end
          end
        end
        ST_HLOAD: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd8) begin
            state <= ST_ROUND;
            cnt   <= '0;
          end
        end
        ST_ROUND: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd64) begin
            state <= ST_HADD;
            cnt   <= '0;
          end
        end
        ST_HADD: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd8) begin
            cnt <= '0;
            if (final_blk) begin
              state <= ST_ORD;
            end else if (extra) begin
              state <= ST_PAD;
              extra <= 1'b0;
            end else if (pad_pending) begin
              state       <= ST_MARK;
              pad_pending <= 1'b0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_MARK: begin
          if (widx == 4'd15) begin
            extra     <= 1'b1;
            final_blk <= 1'b0;
            state     <= ST_HLOAD;
            cnt       <= '0;
          end else begin
            extra <= (widx == 4'd14);
            cnt   <= {3'b000, widx + 4'd1};
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (cnt[3:0] == 4'd15) begin
            final_blk <= !extra;
            state     <= ST_HLOAD;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        ST_ORD: begin
          state <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (digest.ready) begin
            if (cnt[2:0] == last_idx) begin
              state <= ST_INIT;
              cnt   <= '0;
            end else begin
              state <= ST_ORD;
              cnt   <= cnt + 7'd1;
            end
          end
        end
        default: begin
          state <= ST_INIT;
          cnt   <= '0;
        end
      endcase
    end
  end

  shs_word_ram #(.DATA_W(32), .ADDR_W(4)) u_block_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_wa),
    .wr_data (b_wd),
    .rd_en   (b_re),
    .rd_addr (b_ra),
    .rd_data (b_rd)
  );

  shs_word_ram #(.DATA_W(32), .ADDR_W(3)) u_hash_ram (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_wa),
    .wr_data (h_wd),
    .rd_en   (h_re),
    .rd_addr (h_ra),
    .rd_data (h_rd)
  );

  shs_round u_round (
    .clk        (clk),
    .ctrl       (ctrl),
    .k          (round_k(k_idx)),
    .block_word (b_rd),
    .hash_word  (h_rd),
    .v0         (v0)
  );

  a_eom_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (acc && msg.end_of_message && !(cfg.valid)) |=> !msg.ready)
    else $error("input accepted right after end of message");

  a_last_word_index: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.last_word) |-> (digest.word_index == last_idx))
    else $error("last digest word at wrong index");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input taken while digest pending");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (cnt <= 7'd64))
    else $error("round counter overrun");

  a_hash_port_split: assert property (@(posedge clk) disable iff (rst)
    (h_we && h_re) |-> (h_wa != h_ra))
    else $error("hash memory read and write collide");
endmodule
`default_nettype wire

// ===== dv/tb_channels.sv =====
// Testbench-side settings for the hasher channels: idle percentage of each side.
// The channel interfaces themselves come from rtl/shs_if.sv.
`timescale 1ns / 100ps
package tb_chan_pkg;
  localparam int IdlePct = 14;
endpackage

// ===== dv/tb_top.sv =====
// Self-checking testbench of sha256_stream_hasher_unit: streams random and
// directed messages, predicts SHA-256/224 digests and checks each word.
// Depends on tb_chan_pkg, shs_pkg, shs_if and the RTL of the hasher.
`timescale 1ns / 100ps
module tb_top;
  import tb_chan_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        eom;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  shs_in_if  msg ();
  shs_out_if digest ();
  shs_cfg_if cfg ();

  sha256_stream_hasher_unit dut (.clk(clk), .rst(rst), .msg(msg.sink),
                                 .digest(digest.source), .cfg(cfg.sink));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0] kconst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  logic [31:0] iv256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  logic [31:0] iv224 [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
                             32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

  logic        sha_mode;
  logic [31:0] sha_state [8];
  logic [7:0]  blk_bytes [64];
  logic [63:0] bit_len;
  logic [5:0]  fill;

  msg_item_t    pending_msgs [$];
  digest_item_t expected_digest [$];
  bit   failed = 1'b0;
  bit   in_calm = 1'b0;
  int   idle_cycles = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) sha_state[i] = sha_mode ? iv224[i] : iv256[i];
    bit_len = '0;
    fill = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = sha_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) sha_state[i] += v[i];
  endtask

  task automatic append_byte(logic [7:0] b);
    blk_bytes[fill] = b;
    fill = fill + 1'b1;
    if (fill == 0) compress();
  endtask

  task automatic hash_transaction(msg_item_t it);
    int n;
    int nwords;
    n = (it.nbytes > 4) ? 4 : it.nbytes;
    for (int i = 0; i < n; i++) append_byte(it.word[31 - 8*i -: 8]);
    bit_len += 64'(n * 8);
    if (!it.eom) return;
    blk_bytes[fill] = 8'h80;
    fill = fill + 1'b1;
    if (fill == 0 || fill > 56) begin
      while (fill != 0) begin
        blk_bytes[fill] = 8'h00;
        fill = fill + 1'b1;
      end
      compress();
    end
    while (fill < 56) begin
      blk_bytes[fill] = 8'h00;
      fill = fill + 1'b1;
    end
    for (int i = 0; i < 8; i++) blk_bytes[63 - i] = bit_len[8*i +: 8];
    compress();
    nwords = sha_mode ? 7 : 8;
    for (int i = 0; i < nwords; i++)
      expected_digest.push_back('{sha_state[i], 3'(i), i == nwords - 1});
    restart_message();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      msg.valid <= 1'b0;
    end else if (!msg.valid || msg.ready) begin
      if (msg.valid) hash_transaction('{msg.message_word, msg.byte_count, msg.end_of_message});
      if (pending_msgs.size() > 0 && (in_calm || $urandom_range(99) >= IdlePct)) begin
        msg_item_t it;
        it = pending_msgs.pop_front();
        msg.valid <= 1'b1;
        msg.message_word <= it.word;
        msg.byte_count <= it.nbytes;
        msg.end_of_message <= it.eom;
      end else begin
        msg.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      digest.ready <= 1'b0;
    end else begin
      if (digest.valid && digest.ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest transaction %h", $time, digest.digest_word);
          failed = 1'b1;
        end else begin
          digest_item_t e;
          e = expected_digest.pop_front();
          if (e.word !== digest.digest_word || e.idx !== digest.word_index ||
              e.last !== digest.last_word) begin
            $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     e.word, e.idx, e.last, digest.digest_word, digest.word_index,
                     digest.last_word);
            failed = 1'b1;
          end
        end
      end
      digest.ready <= in_calm || $urandom_range(99) >= IdlePct;
    end
  end

  always @(posedge clk) begin
    if (rst || (msg.valid && msg.ready) || (digest.valid && digest.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("sha256_stream_hasher_unit regression: fail");
      $finish;
    end
  end

  task automatic queue_message(int nitems, bit ragged);
    msg_item_t it;
    for (int i = 0; i < nitems; i++) begin
      it.word = $urandom();
      it.nbytes = ragged ? 3'($urandom_range(7)) : 3'd4;
      it.eom = (i == nitems - 1);
      pending_msgs.push_back(it);
    end
  endtask

  task automatic write_mode(logic m);
    wait (pending_msgs.size() == 0 && !msg.valid && expected_digest.size() == 0);
    repeat (40) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.digest_mode <= m;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sha_mode = m;
    restart_message();
  endtask

  initial begin
    int sent;
    msg.valid = 1'b0;
    msg.message_word = '0;
    msg.byte_count = '0;
    msg.end_of_message = 1'b0;
    digest.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.digest_mode = 1'b0;
    sha_mode = 1'b0;
    restart_message();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    pending_msgs.push_back('{32'h0, 3'd0, 1'b1});
    pending_msgs.push_back('{32'h61626300, 3'd3, 1'b1});
    pending_msgs.push_back('{32'hffffffff, 3'd0, 1'b0});
    pending_msgs.push_back('{32'hffffffff, 3'd7, 1'b0});
    pending_msgs.push_back('{32'h00000000, 3'd5, 1'b0});
    pending_msgs.push_back('{32'haaaaaaaa, 3'd6, 1'b0});
    pending_msgs.push_back('{32'h55555555, 3'd1, 1'b0});
    pending_msgs.push_back('{32'h12345678, 3'd2, 1'b1});
    for (int i = 0; i < 14; i++)
      pending_msgs.push_back('{32'hffffffff, 3'd4, i == 13});
    write_mode(1'b1);
    pending_msgs.push_back('{32'h61626300, 3'd3, 1'b1});
    queue_message(16, 1'b0);
    pending_msgs.push_back('{32'h80000001, 3'd4, 1'b0});
    write_mode(1'b1);
    pending_msgs.push_back('{32'h0, 3'd0, 1'b1});
    write_mode(1'b0);
    sent = 0;
    while (sent < 250) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
      queue_message(n, $urandom_range(3) != 0);
      sent += n;
      if (sent > 120 && sent < 200) in_calm = 1'b1;
      else in_calm = 1'b0;
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(3) == 0) queue_message($urandom_range(1, 5), 1'b1);
        write_mode(1'($urandom_range(1)));
      end
      wait (pending_msgs.size() < 20);
    end
    queue_message(3, 1'b1);
    wait (pending_msgs.size() == 0 && !msg.valid && expected_digest.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed && expected_digest.size() == 0) begin
      $display("sha256_stream_hasher_unit regression: pass");
    end else begin
      $display("sha256_stream_hasher_unit regression: fail");
    end
    $finish;
  end
endmodule
